[rtl/dap_pkg.sv]
// Shared types and codes for the DWARF abbreviation section parser.
// No dependencies; imported by dap_leb_decode and dwarf_abbrev_compile_unit_parser.
`timescale 1ns / 1ps
`default_nettype none

package dap_pkg;

    // Parse position inside one abbreviation entry
    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_CHILD = 3'd2,
        PH_ATTR  = 3'd3,
        PH_FORM  = 3'd4
    } phase_t;

    // Result kind carried on the master tuser
    typedef enum logic [2:0] {
        ST_PAIR     = 3'd0,
        ST_LIST_END = 3'd1,
        ST_FINISHED = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_OVERLONG = 3'd4,
        ST_BAD_TERM = 3'd5
    } status_t;

    // Per-byte LEB128 decode flags
    typedef struct packed {
        logic more;      // continuation bit set, value still open
        logic overlong;  // continuation set on the last allowed byte
    } leb_flags_t;

    localparam logic [31:0] MATCH_TAG_RESET = 32'd17;

endpackage : dap_pkg

`default_nettype wire

[rtl/dwarf_abbrev_compile_unit_parser.sv]
// Top level of the DWARF abbreviation section parser.
// Depends on dap_pkg and dap_leb_decode.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Slave stream s_*: one section byte per transfer in s_tdata, s_tlast marks
//   the last byte of the section.
//   Master stream m_*: zero or one result per byte. m_tuser holds the status
//   (pair, list end, finished, truncated, overlong, bad terminator); m_tdata
//   holds abbreviation number, attribute and form, low 32 bits each.
//   cfg_we/cfg_wdata write the tag whose attribute lists are reported
//   (17, compile unit, after reset); write only while the block is idle.
// Timing:
//   A byte is decoded in the cycle it is accepted; its result appears on the
//   master side in the next cycle. One byte per cycle is sustained while no
//   result is held, set by the combinational LEB merge and phase update.
// Stalls:
//   s_tready stays high while the output register is empty or being drained.
//   A result held by the receiver stalls every byte, including bytes that
//   would give no result, until m_tready returns.
// Reset:
//   rst_n clears the parse state, drops any pending result and restores the
//   match tag. After a finish or an error every byte is consumed silently
//   until the next reset.
module dwarf_abbrev_compile_unit_parser
    import dap_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,   // match_tag

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tlast,     // section_end

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [95:0] m_tdata,     // [31:0] abbrev_code, [63:32] attr_name,
                                          // [95:64] attr_form
    output      logic [2:0]  m_tuser      // [2:0] status
);

    localparam int LEB_MAX_BYTES = (VALUE_BITS + 6) / 7;
    localparam int CNT_W         = $clog2(LEB_MAX_BYTES + 1);

    // Parse state
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] accum_reg, accum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] code_reg, code_next;
    logic [VALUE_BITS-1:0] attr_reg, attr_next;
    logic                  match_reg, match_next;
    logic                  stopped_reg, stopped_next;
    logic [31:0]           tag_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [31:0]           out_code_reg, out_attr_reg, out_form_reg;

    // Result of the current byte
    logic                  res_valid;
    status_t               res_status;
    logic [31:0]           res_code, res_attr, res_form;

    logic                  s_accept;
    logic                  load;

    // LEB step outputs
    logic [VALUE_BITS-1:0] leb_value;
    logic [CNT_W-1:0]      leb_count_inc;
    leb_flags_t            leb_flags;

    logic [VALUE_BITS+31:0] code_ext, attr_ext, value_ext, tag_cmp_v, tag_cmp_t;
    logic                   tag_hit;

    dap_leb_decode
    #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    )
    u_leb
    (
        .data_byte  (s_tdata),
        .accum      (accum_reg),
        .count      (count_reg),
        .accum_next (leb_value),
        .count_inc  (leb_count_inc),
        .flags      (leb_flags)
    );

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    // Widened copies for 32-bit outputs and tag compare
    always_comb
    begin
        code_ext  = {32'd0, code_reg};
        attr_ext  = {32'd0, attr_reg};
        value_ext = {32'd0, leb_value};
        tag_cmp_v = {32'd0, leb_value};
        tag_cmp_t = {{VALUE_BITS{1'b0}}, tag_reg};
        tag_hit   = (tag_cmp_v == tag_cmp_t);
    end

    // Byte decode: phase transitions and result selection
    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        count_next   = count_reg;
        code_next    = code_reg;
        attr_next    = attr_reg;
        match_next   = match_reg;
        stopped_next = stopped_reg;
        res_valid    = 1'b0;
        res_status   = ST_PAIR;
        res_code     = 32'd0;
        res_attr     = 32'd0;
        res_form     = 32'd0;

        if (s_accept && !stopped_reg)
        begin
            if (phase_reg == PH_CHILD)
            begin
                // has-children byte is skipped
                if (s_tlast)
                begin
                    stopped_next = 1'b1;
                    res_valid    = 1'b1;
                    res_status   = ST_TRUNC;
                end
                else
                begin
                    phase_next = PH_ATTR;
                end
            end
            else if (leb_flags.more)
            begin
                accum_next = leb_value;
                count_next = leb_count_inc;
                if (leb_flags.overlong)
                begin
                    stopped_next = 1'b1;
                    res_valid    = 1'b1;
                    res_status   = ST_OVERLONG;
                end
                else if (s_tlast)
                begin
                    stopped_next = 1'b1;
                    res_valid    = 1'b1;
                    res_status   = ST_TRUNC;
                end
            end
            else
            begin
                // value complete
                accum_next = '0;
                count_next = '0;
                if (phase_reg == PH_CODE && leb_value == '0)
                begin
                    stopped_next = 1'b1;
                    res_valid    = 1'b1;
                    res_status   = ST_FINISHED;
                end
                else if (s_tlast)
                begin
                    stopped_next = 1'b1;
                    res_valid    = 1'b1;
                    res_status   = ST_TRUNC;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_CODE:
                        begin
                            code_next  = leb_value;
                            phase_next = PH_TAG;
                        end
                        PH_TAG:
                        begin
                            match_next = tag_hit;
                            phase_next = PH_CHILD;
                        end
                        PH_ATTR:
                        begin
                            attr_next  = leb_value;
                            phase_next = PH_FORM;
                        end
                        default:
                        begin
                            if ((attr_reg == '0) != (leb_value == '0))
                            begin
                                stopped_next = 1'b1;
                                res_valid    = 1'b1;
                                res_status   = ST_BAD_TERM;
                            end
                            else if (attr_reg == '0)
                            begin
                                phase_next = PH_CODE;
                                res_valid  = match_reg;
                                res_status = ST_LIST_END;
                                res_code   = code_ext[31:0];
                            end
                            else
                            begin
                                phase_next = PH_ATTR;
                                res_valid  = match_reg;
                                res_status = ST_PAIR;
                                res_code   = code_ext[31:0];
                                res_attr   = attr_ext[31:0];
                                res_form   = value_ext[31:0];
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign load = res_valid;

    // Output valid tracking
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CODE;
            accum_reg     <= '0;
            count_reg     <= '0;
            code_reg      <= '0;
            attr_reg      <= '0;
            match_reg     <= 1'b0;
            stopped_reg   <= 1'b0;
            tag_reg       <= MATCH_TAG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            code_reg      <= code_next;
            attr_reg      <= attr_next;
            match_reg     <= match_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                tag_reg <= cfg_wdata;
        end
    end

    // Result payload, loaded with each new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= res_status;
            out_code_reg   <= res_code;
            out_attr_reg   <= res_attr;
            out_form_reg   <= res_form;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_form_reg, out_attr_reg, out_code_reg};

`ifndef SYNTHESIS
    // Once stopped, the parser never resumes before reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("parser left stopped state without reset");

    // While parsing, an open value never reaches the length limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg || (count_reg < CNT_W'(LEB_MAX_BYTES)))
        else $error("LEB byte count reached limit while still parsing");

    // The skipped has-children byte follows a completed value
    a_child_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHILD) |-> (count_reg == '0 && accum_reg == '0))
        else $error("LEB accumulator not cleared before has-children byte");

    // Terminal results always stop the parser
    a_terminal_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_status != ST_PAIR && res_status != ST_LIST_END) |=> stopped_reg)
        else $error("terminal result did not stop the parser");

    // Nothing is produced once stopped
    a_quiet_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !load)
        else $error("result produced after parser stopped");
`endif

endmodule : dwarf_abbrev_compile_unit_parser

`default_nettype wire

[rtl/dap_leb_decode.sv]
// One step of unsigned LEB128 decoding: merges a byte into the running value.
// Depends on dap_pkg (leb_flags_t).
`timescale 1ns / 1ps
`default_nettype none

module dap_leb_decode
    import dap_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 3
)
(
    input  wire logic [7:0]            data_byte,
    input  wire logic [VALUE_BITS-1:0] accum,
    input  wire logic [CNT_W-1:0]      count,
    output      logic [VALUE_BITS-1:0] accum_next,
    output      logic [CNT_W-1:0]      count_inc,
    output      leb_flags_t            flags
);

    localparam int LEB_MAX_BYTES = (VALUE_BITS + 6) / 7;

    logic [VALUE_BITS+6:0] shifted;

    // Place the seven payload bits; bits beyond the value width fall off
    always_comb
    begin
        shifted    = {{VALUE_BITS{1'b0}}, data_byte[6:0]} << (7 * int'(count));
        accum_next = accum | shifted[VALUE_BITS-1:0];
        count_inc  = count + CNT_W'(1);
    end

    // Continuation and length check
    always_comb
    begin
        flags.more     = data_byte[7];
        flags.overlong = data_byte[7] && (count_inc >= CNT_W'(LEB_MAX_BYTES));
    end

endmodule : dap_leb_decode

`default_nettype wire
